[src/mmfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmfp_pkg
// Shared types, field codes and per-type layout tables for the mesh message
// field parser.
// ----------------------------------------------------------------------------
package mmfp_pkg;

   // frame size limit, byte counter saturates one above it
   localparam logic [8:0] MAX_FRAME_BYTES = 9'd255;

   // highest offset reported inside one field
   localparam logic [7:0] OFFSET_MAX = 8'd254;

   // highest known message type
   localparam logic [3:0] MSG_KIND_MAX = 4'd10;

   // type nibble and answer-required bit in the first byte
   localparam logic [7:0] TYPE_MASK  = 8'h0F;
   localparam int unsigned ANSWER_BIT = 6;

   // number of layout entries a table row holds
   localparam int unsigned NUM_STEPS = 8;

   // field codes on the result beat
   localparam logic [3:0] FK_HEADER     = 4'd0;
   localparam logic [3:0] FK_PREFIX     = 4'd1;
   localparam logic [3:0] FK_SENDER     = 4'd2;
   localparam logic [3:0] FK_MAC        = 4'd3;
   localparam logic [3:0] FK_ORDER      = 4'd4;
   localparam logic [3:0] FK_NETID      = 4'd5;
   localparam logic [3:0] FK_IP         = 4'd6;
   localparam logic [3:0] FK_ROLES      = 4'd7;
   localparam logic [3:0] FK_MSGID      = 4'd8;
   localparam logic [3:0] FK_INIT_SSID  = 4'd9;
   localparam logic [3:0] FK_DEST_SSID  = 4'd10;
   localparam logic [3:0] FK_PAYLOAD    = 4'd11;
   localparam logic [3:0] FK_UNUSED     = 4'd12;

   // number of layout entries per message type
   localparam logic [3:0] LAY_N [0:10] = '{
      4'd0, 4'd7, 4'd5, 4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd3, 4'd7, 4'd8
   };

   // field code of each layout entry
   localparam logic [3:0] LAY_KIND [0:10][0:NUM_STEPS-1] = '{
      '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd1,  4'd2,  4'd3,  4'd1,  4'd4,  4'd5,  4'd6,  4'd0},
      '{4'd1,  4'd2,  4'd3,  4'd7,  4'd6,  4'd0,  4'd0,  4'd0},
      '{4'd1,  4'd2,  4'd5,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd1,  4'd2,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd1,  4'd2,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd8,  4'd1,  4'd2,  4'd7,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd8,  4'd1,  4'd2,  4'd5,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd8,  4'd1,  4'd2,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd1,  4'd2,  4'd1,  4'd9,  4'd7,  4'd1,  4'd11, 4'd0},
      '{4'd1,  4'd2,  4'd1,  4'd9,  4'd1,  4'd10, 4'd1,  4'd11}
   };

   // fixed size of each layout entry, zero when sized by the prefix before it
   localparam logic [2:0] LAY_LEN [0:10][0:NUM_STEPS-1] = '{
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd1, 3'd0, 3'd6, 3'd1, 3'd1, 3'd4, 3'd4, 3'd0},
      '{3'd1, 3'd0, 3'd6, 3'd4, 3'd4, 3'd0, 3'd0, 3'd0},
      '{3'd1, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd4, 3'd1, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd4, 3'd1, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd4, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd1, 3'd0, 3'd1, 3'd0, 3'd4, 3'd1, 3'd0, 3'd0},
      '{3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0}
   };

   // position in the layout walk
   typedef struct packed {
      logic [3:0] step;
      logic [7:0] remaining;
   } layout_pos_type;

   // enter a layout entry, skipping an empty prefixed field; the tables never
   // hold two prefix-sized entries in a row, so one skip is enough
   function automatic layout_pos_type enter_step(
      input logic [3:0] kind,
      input logic [3:0] step,
      input logic [7:0] prefix
   );
      layout_pos_type res;
      logic [3:0]     nxt;
      logic [3:0]     num;
      logic [2:0]     len_a;
      logic [2:0]     len_b;
      num   = LAY_N[kind];
      nxt   = step + 4'd1;
      len_a = LAY_LEN[kind][step[2:0]];
      len_b = LAY_LEN[kind][nxt[2:0]];
      if (step >= num) begin
         res.step      = num;
         res.remaining = 8'd0;
      end else if (len_a != 3'd0) begin
         res.step      = step;
         res.remaining = {5'd0, len_a};
      end else if (prefix != 8'd0) begin
         res.step      = step;
         res.remaining = prefix;
      end else if (nxt >= num) begin
         res.step      = num;
         res.remaining = 8'd0;
      end else begin
         res.step      = nxt;
         res.remaining = {5'd0, len_b};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

[src/mesh_message_field_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_message_field_parser
// Tags each byte of a mesh control frame with its field and offset, and judges
// the frame on its last byte.
// ----------------------------------------------------------------------------
// One byte enters per beat on the req_ channel and leaves next cycle as a
// tagged beat on the rsp_ channel, so the block takes a byte every cycle while
// the result side keeps up; its only limit is the single output register,
// which stalls the input only while a result sits untaken. The first byte
// sets the message type and answer-required flag, the second the declared
// length; after that the per-type layout tables drive a small walker (entry
// number, bytes left, offset). The beat marked end_of_frame carries
// frame_done and frame_error, and the parser is back at its start for the
// next frame on the following byte.
module mesh_message_field_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_end_of_frame,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_value,
   output logic [3:0]      rsp_field_kind,
   output logic [7:0]      rsp_field_offset,
   output logic [3:0]      rsp_message_kind,
   output logic            rsp_answer_required,
   output logic            rsp_frame_done,
   output logic            rsp_frame_error
);

   // frame state
   logic [8:0] count_ff,  count_in;
   logic [3:0] kind_ff,   kind_in;
   logic       answer_ff, answer_in;
   logic [7:0] decl_ff,   decl_in;
   logic [3:0] step_ff,   step_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] offset_ff, offset_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic [3:0] fkind_ff,  fkind_in;
   logic [7:0] foffset_ff, foffset_in;
   logic [3:0] mkind_ff;
   logic       mans_ff;
   logic       done_ff;
   logic       error_ff,  error_in;

   // working values
   logic                    accept;
   logic [3:0]              type_nib;
   logic [3:0]              kind_upd;
   logic                    answer_upd;
   logic [7:0]              decl_upd;
   logic [8:0]              count_upd;
   logic [3:0]              step_upd;
   logic [7:0]              remain_upd;
   logic [7:0]              offset_upd;
   logic [3:0]              cur_kind;
   logic [7:0]              remain_dec;
   logic [7:0]              offset_inc;
   mmfp_pkg::layout_pos_type pos_first;
   mmfp_pkg::layout_pos_type pos_next;

   // handshake: take a byte whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // layout lookups
   assign type_nib   = req_rx_byte[3:0] & mmfp_pkg::TYPE_MASK[3:0];
   assign cur_kind   = mmfp_pkg::LAY_KIND[kind_ff][step_ff[2:0]];
   assign remain_dec = (remain_ff != 8'd0) ? remain_ff - 8'd1 : remain_ff;
   assign offset_inc = (offset_ff < mmfp_pkg::OFFSET_MAX) ? offset_ff + 8'd1 : offset_ff;
   assign pos_first  = mmfp_pkg::enter_step(kind_ff, 4'd0, 8'd0);
   assign pos_next   = mmfp_pkg::enter_step(kind_ff, step_ff + 4'd1,
                          (cur_kind == mmfp_pkg::FK_PREFIX) ? req_rx_byte : 8'd0);

   // per-byte tagging and state update
   always_comb begin
      kind_upd   = kind_ff;
      answer_upd = answer_ff;
      decl_upd   = decl_ff;
      step_upd   = step_ff;
      remain_upd = remain_ff;
      offset_upd = offset_ff;
      fkind_in   = mmfp_pkg::FK_HEADER;
      foffset_in = 8'd0;
      if (count_ff == 9'd0) begin
         kind_upd   = (type_nib >= 4'd1 && type_nib <= mmfp_pkg::MSG_KIND_MAX) ?
                      type_nib : 4'd0;
         answer_upd = req_rx_byte[mmfp_pkg::ANSWER_BIT];
      end else if (count_ff == 9'd1) begin
         decl_upd   = req_rx_byte;
         foffset_in = 8'd1;
         step_upd   = pos_first.step;
         remain_upd = pos_first.remaining;
         offset_upd = 8'd0;
      end else begin
         foffset_in = offset_ff;
         offset_upd = offset_inc;
         if (step_ff >= mmfp_pkg::LAY_N[kind_ff]) begin
            fkind_in = mmfp_pkg::FK_UNUSED;
         end else begin
            fkind_in   = cur_kind;
            remain_upd = remain_dec;
            if (remain_dec == 8'd0) begin
               step_upd   = pos_next.step;
               remain_upd = pos_next.remaining;
               offset_upd = 8'd0;
            end
         end
      end
   end

   // byte counter saturates one above the frame limit
   assign count_upd = (count_ff <= mmfp_pkg::MAX_FRAME_BYTES) ? count_ff + 9'd1 : count_ff;

   // frame judgement on the last byte
   assign error_in = req_end_of_frame &&
                     (count_upd < 9'd2 || count_upd > mmfp_pkg::MAX_FRAME_BYTES ||
                      kind_upd == 4'd0 || {1'b0, decl_upd} != count_upd);

   // back to the start after the last byte
   always_comb begin
      if (req_end_of_frame) begin
         count_in  = 9'd0;
         kind_in   = 4'd0;
         answer_in = 1'b0;
         decl_in   = 8'd0;
         step_in   = 4'd0;
         remain_in = 8'd0;
         offset_in = 8'd0;
      end else begin
         count_in  = count_upd;
         kind_in   = kind_upd;
         answer_in = answer_upd;
         decl_in   = decl_upd;
         step_in   = step_upd;
         remain_in = remain_upd;
         offset_in = offset_upd;
      end
   end

   // output valid
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= 9'd0;
         kind_ff      <= 4'd0;
         answer_ff    <= 1'b0;
         decl_ff      <= 8'd0;
         step_ff      <= 4'd0;
         remain_ff    <= 8'd0;
         offset_ff    <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            kind_ff   <= kind_in;
            answer_ff <= answer_in;
            decl_ff   <= decl_in;
            step_ff   <= step_in;
            remain_ff <= remain_in;
            offset_ff <= offset_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff    <= req_rx_byte;
         fkind_ff   <= fkind_in;
         foffset_ff <= foffset_in;
         mkind_ff   <= kind_upd;
         mans_ff    <= answer_upd;
         done_ff    <= req_end_of_frame;
         error_ff   <= error_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_value      = byte_ff;
   assign rsp_field_kind      = fkind_ff;
   assign rsp_field_offset    = foffset_ff;
   assign rsp_message_kind    = mkind_ff;
   assign rsp_answer_required = mans_ff;
   assign rsp_frame_done      = done_ff;
   assign rsp_frame_error     = error_ff;

   // a new result beat only follows an accepted byte
   a_valid_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result beat without accepted byte");

   // error flag only on the closing beat
   a_error_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && error_ff |-> done_ff)
      else $error("frame error outside closing beat");

   // parser restarts after the last byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_frame |=> count_ff == 9'd0 && step_ff == 4'd0)
      else $error("parser did not restart after frame end");

   // walker never runs past the type's layout
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      kind_ff <= mmfp_pkg::MSG_KIND_MAX && step_ff <= mmfp_pkg::LAY_N[kind_ff])
      else $error("layout walker out of range");

   // offset stays within its saturation limit
   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= mmfp_pkg::OFFSET_MAX)
      else $error("field offset beyond limit");

endmodule
`default_nettype wire

[sim/mmfp_tag_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfp_tag_checker
// Watches both channels of the mesh message field parser, works out the tag of
// every accepted byte on its own and compares each result beat with it.
// ----------------------------------------------------------------------------
module mmfp_tag_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_end_of_frame,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_byte_value,
   input  wire logic [3:0] rsp_field_kind,
   input  wire logic [7:0] rsp_field_offset,
   input  wire logic [3:0] rsp_message_kind,
   input  wire logic       rsp_answer_required,
   input  wire logic       rsp_frame_done,
   input  wire logic       rsp_frame_error,
   output int unsigned     mismatch_count,
   output int unsigned     beats_outstanding
);

   localparam int unsigned MAX_PRINTED = 30;

   // entries per message type
   localparam int unsigned WALK_LEN [0:10] = '{0, 7, 5, 3, 2, 2, 4, 4, 3, 7, 8};

   // field carried by each entry of a type's layout
   localparam logic [3:0] WALK_FIELD [0:10][0:7] = '{
      '{mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_MAC, mmfp_pkg::FK_PREFIX,
        mmfp_pkg::FK_ORDER, mmfp_pkg::FK_NETID, mmfp_pkg::FK_IP, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_MAC, mmfp_pkg::FK_ROLES,
        mmfp_pkg::FK_IP, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_NETID, mmfp_pkg::FK_HEADER,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_MSGID, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_ROLES,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_MSGID, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_NETID,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_MSGID, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_HEADER,
        mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_INIT_SSID,
        mmfp_pkg::FK_ROLES, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_PAYLOAD, mmfp_pkg::FK_HEADER},
      '{mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_SENDER, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_INIT_SSID,
        mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_DEST_SSID, mmfp_pkg::FK_PREFIX, mmfp_pkg::FK_PAYLOAD}
   };

   // fixed size of each entry, zero where the prefix byte before it sets the size
   localparam int unsigned WALK_SIZE [0:10][0:7] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 6, 1, 1, 4, 4, 0},
      '{1, 0, 6, 4, 4, 0, 0, 0},
      '{1, 0, 4, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0},
      '{4, 1, 0, 4, 0, 0, 0, 0},
      '{4, 1, 0, 4, 0, 0, 0, 0},
      '{4, 1, 0, 0, 0, 0, 0, 0},
      '{1, 0, 1, 0, 4, 1, 0, 0},
      '{1, 0, 1, 0, 1, 0, 1, 0}
   };

   typedef struct packed {
      logic [7:0] byte_value;
      logic [3:0] field_kind;
      logic [7:0] field_offset;
      logic [3:0] message_kind;
      logic       answer_required;
      logic       frame_done;
      logic       frame_error;
   } tagged_beat_type;

   // parser state as the predictor sees it
   logic [8:0]  frame_bytes;
   logic [3:0]  frame_type;
   logic        answer_bit;
   logic [7:0]  length_field;
   int unsigned walk_step;
   logic [7:0]  walk_left;
   logic [7:0]  walk_offset;

   tagged_beat_type expected_tags[$];
   tagged_beat_type want;
   int unsigned     fail_total = 0;

   assign mismatch_count    = fail_total;

   function automatic void clear_frame();
      frame_bytes  = '0;
      frame_type   = '0;
      answer_bit   = 1'b0;
      length_field = '0;
      walk_step    = 0;
      walk_left    = '0;
      walk_offset  = '0;
   endfunction

   // move to a layout entry, stepping over prefixed fields of size zero
   function automatic void walk_enter(input int unsigned step, input logic [7:0] prefix);
      walk_offset = '0;
      while (step < WALK_LEN[frame_type]) begin
         if (WALK_SIZE[frame_type][step] != 0) begin
            walk_step = step;
            walk_left = 8'(WALK_SIZE[frame_type][step]);
            return;
         end
         if (prefix != 8'd0) begin
            walk_step = step;
            walk_left = prefix;
            return;
         end
         step++;
         prefix = 8'd0;
      end
      walk_step = WALK_LEN[frame_type];
      walk_left = '0;
   endfunction

   // tag one received byte and advance the parser state
   function automatic tagged_beat_type tag_byte(input logic [7:0] b, input logic eof);
      tagged_beat_type r;
      r            = '0;
      r.byte_value = b;
      r.frame_done = eof;
      if (frame_bytes == 9'd0) begin
         frame_type   = (b[3:0] >= 4'd1 && b[3:0] <= mmfp_pkg::MSG_KIND_MAX) ?
                        b[3:0] : 4'd0;
         answer_bit   = b[mmfp_pkg::ANSWER_BIT];
         r.field_kind = mmfp_pkg::FK_HEADER;
      end else if (frame_bytes == 9'd1) begin
         length_field   = b;
         r.field_kind   = mmfp_pkg::FK_HEADER;
         r.field_offset = 8'd1;
         walk_enter(0, 8'd0);
      end else begin
         r.field_offset = walk_offset;
         if (walk_step >= WALK_LEN[frame_type]) begin
            // past the end of the layout, or a type with no layout
            r.field_kind = mmfp_pkg::FK_UNUSED;
            if (walk_offset < mmfp_pkg::OFFSET_MAX) walk_offset++;
         end else begin
            r.field_kind = WALK_FIELD[frame_type][walk_step];
            if (walk_left != 8'd0) walk_left--;
            if (walk_offset < mmfp_pkg::OFFSET_MAX) walk_offset++;
            if (walk_left == 8'd0)
               walk_enter(walk_step + 1,
                          (r.field_kind == mmfp_pkg::FK_PREFIX) ? b : 8'd0);
         end
      end
      if (frame_bytes <= mmfp_pkg::MAX_FRAME_BYTES) frame_bytes++;
      r.message_kind    = frame_type;
      r.answer_required = answer_bit;
      // judge the frame on its last byte
      if (eof) begin
         r.frame_error = (frame_bytes < 9'd2) ||
                         (frame_bytes > mmfp_pkg::MAX_FRAME_BYTES) ||
                         (frame_type == 4'd0) || ({1'b0, length_field} != frame_bytes);
         clear_frame();
      end
      return r;
   endfunction

   task automatic report(input string msg);
      fail_total++;
      if (fail_total <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] exp_val);
      if (got !== exp_val)
         report($sformatf("%s got %0d wanted %0d (byte 0x%02h)",
                          name, got, exp_val, want.byte_value));
   endtask

   // predict on every accepted input beat, compare on every accepted result beat
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         expected_tags.delete();
         beats_outstanding <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_tags.push_back(tag_byte(req_rx_byte, req_end_of_frame));
         if (rsp_valid && rsp_ready) begin
            if (expected_tags.size() == 0) begin
               report($sformatf("result beat 0x%02h with nothing expected", rsp_byte_value));
            end else begin
               want = expected_tags.pop_front();
               check_field("byte_value", rsp_byte_value, want.byte_value);
               check_field("field_kind", 8'(rsp_field_kind), 8'(want.field_kind));
               check_field("field_offset", rsp_field_offset, want.field_offset);
               check_field("message_kind", 8'(rsp_message_kind), 8'(want.message_kind));
               check_field("answer_required", 8'(rsp_answer_required),
                           8'(want.answer_required));
               check_field("frame_done", 8'(rsp_frame_done), 8'(want.frame_done));
               check_field("frame_error", 8'(rsp_frame_error), 8'(want.frame_error));
            end
         end
         beats_outstanding <= expected_tags.size();
      end
   end

endmodule
`default_nettype wire

[sim/mesh_message_field_parser_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_message_field_parser_tb
// Feeds the field parser directed and random mesh frames, well-formed, broken,
// unknown-type and oversized, under bursty input and a stalling result side;
// a checker beside the block predicts every tagged beat.
// ----------------------------------------------------------------------------
module mesh_message_field_parser_tb;

   localparam int unsigned RANDOM_BYTES   = 1250;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 8;

   typedef enum int unsigned {
      READY_ALWAYS,
      READY_COIN,
      READY_ONE_IN_FOUR,
      READY_RARE
   } stall_mode_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_rx_byte      = 8'd0;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_ready        = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_byte_value;
   logic [3:0]  rsp_field_kind;
   logic [7:0]  rsp_field_offset;
   logic [3:0]  rsp_message_kind;
   logic        rsp_answer_required;
   logic        rsp_frame_done;
   logic        rsp_frame_error;
   int unsigned mismatch_count;
   int unsigned beats_outstanding;

   logic [7:0]     frame_q[$];
   int unsigned    burst_left   = 0;
   int unsigned    idle_cycles  = 0;
   int unsigned    stall_left   = 0;
   stall_mode_type stall_mode   = READY_ALWAYS;

   mesh_message_field_parser dut (.*);

   mmfp_tag_checker checker_i (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stalls on a pattern chosen anew when its random hold counter runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS:      rsp_ready <= 1'b1;
         READY_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
         READY_ONE_IN_FOUR: rsp_ready <= (stall_left[1:0] == 2'd0);
         default:           rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // watchdog on cycles in which no beat moves
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // present one byte until taken, then maybe leave a gap before the next
   task automatic send_beat(input logic [7:0] value, input logic last);
      req_valid        <= 1'b1;
      req_rx_byte      <= value;
      req_end_of_frame <= last;
      do @(posedge clock); while (!req_ready);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_q.size(); i++) send_beat(frame_q[i], i == frame_q.size() - 1);
   endtask

   // hold off the sender until every expected beat has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_outstanding != 0);
   endtask

   // size of a prefixed field: often empty, mostly short
   function automatic logic [7:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 8'd0;
      if (roll < 85) return 8'($urandom_range(1, 8));
      return 8'($urandom_range(9, 40));
   endfunction

   // well-formed frame of a known type with random content
   task automatic build_layout_frame(input logic [3:0] mtype, input int unsigned trail);
      logic [7:0]  hdr;
      int unsigned field_len;
      int unsigned sized;
      int unsigned step;
      int unsigned i;
      hdr      = 8'($urandom);
      hdr[3:0] = mtype;
      sized    = 0;
      frame_q.delete();
      frame_q.push_back(hdr);
      frame_q.push_back(8'd0);
      for (step = 0; step < mmfp_pkg::LAY_N[mtype]; step++) begin
         field_len = (mmfp_pkg::LAY_LEN[mtype][step] != 3'd0) ?
                     mmfp_pkg::LAY_LEN[mtype][step] : sized;
         for (i = 0; i < field_len; i++) begin
            if (mmfp_pkg::LAY_KIND[mtype][step] == mmfp_pkg::FK_PREFIX) begin
               sized = pick_size();
               frame_q.push_back(8'(sized));
            end else begin
               frame_q.push_back(8'($urandom));
            end
         end
      end
      repeat (trail) frame_q.push_back(8'($urandom));
      frame_q[1] = (frame_q.size() <= 255) ? 8'(frame_q.size()) : 8'($urandom);
   endtask

   // one prefix and its field, then a tail; used for the size extremes
   task automatic build_long(input logic [7:0] hdr, input logic [7:0] prefix,
                             input int unsigned tail);
      frame_q.delete();
      frame_q.push_back(hdr);
      frame_q.push_back(8'd0);
      frame_q.push_back(prefix);
      repeat (int'(prefix) + tail) frame_q.push_back(8'($urandom));
      frame_q[1] = 8'(frame_q.size());
   endtask

   // random bytes under a given type nibble
   task automatic build_noise_frame(input logic [3:0] nib);
      logic [7:0]  hdr;
      int unsigned len;
      len      = $urandom_range(1, 20);
      hdr      = 8'($urandom);
      hdr[3:0] = nib;
      frame_q.delete();
      frame_q.push_back(hdr);
      repeat (len - 1) frame_q.push_back(8'($urandom));
      if (len >= 2 && $urandom_range(0, 1) == 1) frame_q[1] = 8'(len);
   endtask

   initial begin
      int unsigned random_bytes;
      int unsigned frame_no;
      int unsigned roll;
      int unsigned cut;
      int unsigned pick;
      logic [3:0]  mtype;
      random_bytes = 0;
      frame_no     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // lone first byte: too short, unknown type, answer bit set
      frame_q = '{8'hFF};
      send_frame();
      // shortest legal frame, header only
      frame_q = '{8'h04, 8'h02};
      send_frame();
      // empty sender field skipped, then one byte past the layout
      frame_q = '{8'h45, 8'h04, 8'h00, 8'hAA};
      send_frame();
      // type zero is unknown even with a matching length
      frame_q = '{8'h00, 8'h03, 8'h55};
      send_frame();
      // ssid message with every prefixed field empty
      frame_q = '{8'h4A, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      // declared length differs from the count
      frame_q = '{8'h85, 8'h09, 8'h01, 8'h7F};
      send_frame();
      // high type nibble, unknown
      frame_q = '{8'h7E, 8'h02};
      send_frame();
      wait_for_drain();

      // random frames: mostly well-formed, the rest broken or noise
      while (random_bytes < RANDOM_BYTES) begin
         frame_no++;
         roll  = $urandom_range(0, 99);
         mtype = 4'($urandom_range(1, 10));
         if (frame_no == 4) begin
            // largest legal frame
            build_long(8'h44, 8'd252, 0);
         end else if (frame_no == 12) begin
            // overlong, sender offset reaches its limit
            build_long(8'h0A, 8'd255, 4);
         end else if (frame_no == 20) begin
            // overlong unknown type, unused offset saturates
            build_long(8'h5D, 8'd255, 1);
         end else if (roll < 60) begin
            build_layout_frame(mtype, 0);
         end else if (roll < 68) begin
            build_layout_frame(mtype, $urandom_range(1, 4));
         end else if (roll < 76) begin
            build_layout_frame(mtype, 0);
            frame_q[1] = 8'($urandom);
         end else if (roll < 86) begin
            // cut short anywhere, down to a single byte
            build_layout_frame(mtype, 0);
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end else if (roll < 94) begin
            pick = $urandom_range(0, 5);
            build_noise_frame((pick == 0) ? 4'd0 : 4'(mmfp_pkg::MSG_KIND_MAX + pick));
         end else begin
            build_noise_frame(4'($urandom));
         end
         random_bytes += frame_q.size();
         send_frame();
         if ($urandom_range(0, 9) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && beats_outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

[mesh_message_field_parser.f]
src/mmfp_pkg.sv
src/mesh_message_field_parser.sv
sim/mmfp_tag_checker.sv
sim/mesh_message_field_parser_tb.sv
